### hw/rtl/assert_macros.svh
// Assertion macros for the checker file of this block.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

### hw/rtl/ecpa_pkg.sv
// Package for the affine point adder: field width, word types, register indexes,
// sequencer states and modular add/subtract helpers. No dependencies.
package ecpa_pkg;

	// Field element width
	localparam int FIELD_BITS = 16;
	typedef logic [FIELD_BITS-1:0] felem_t;

	// Configuration register indexes
	localparam int CFG_IDX_W = 1;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	localparam cfg_idx_t REG_MODULUS = CFG_IDX_W'(0);
	localparam cfg_idx_t REG_CURVE_A = CFG_IDX_W'(1);

	// Register reset values and small constants
	localparam felem_t MODULUS_RESET = FIELD_BITS'(29);
	localparam felem_t CURVE_A_RESET = FIELD_BITS'(4);
	localparam felem_t FE_ONE        = FIELD_BITS'(1);
	localparam felem_t FE_TWO        = FIELD_BITS'(2);
	localparam felem_t FE_THREE      = FIELD_BITS'(3);

	// Input word: two points with identity flags
	typedef struct packed {
		felem_t first_x;
		felem_t first_y;
		logic   first_inf;
		felem_t second_x;
		felem_t second_y;
		logic   second_inf;
	} pair_word_t;

	// Output word: the sum
	typedef struct packed {
		felem_t sum_x;
		felem_t sum_y;
		logic   sum_inf;
	} sum_word_t;

	// Sequencer states
	typedef enum logic [4:0] {
		ST_IDLE,
		ST_CHECK,
		ST_RED_Y1,
		ST_RED_X2,
		ST_RED_Y2,
		ST_RED_A,
		ST_CASE,
		ST_DBL_3,
		ST_DBL_A,
		ST_INV,
		ST_INV_R,
		ST_INV_B,
		ST_SLOPE,
		ST_X3A,
		ST_X3B,
		ST_Y3A,
		ST_Y3B,
		ST_MUL,
		ST_DONE
	} state_t;

	// (a + b) mod m, both operands already below m
	function automatic felem_t fadd(input felem_t a, input felem_t b, input felem_t m);
		felem_t room;
		room = m - b;
		return (a >= room) ? (a - room) : (a + b);
	endfunction

	// (a - b) mod m, both operands already below m
	function automatic felem_t fsub(input felem_t a, input felem_t b, input felem_t m);
		return (a >= b) ? (a - b) : (a + (m - b));
	endfunction

endpackage

### hw/rtl/ec_affine_point_add_top.sv
// Affine elliptic-curve point adder over GF(p), single module with its sequencer.
// Depends on ecpa_pkg.
//
// Adds two points of y^2 = x^3 + a*x + b given with identity flags. The user
// must write p and a through the cfg port only while the block is idle; the
// block itself does not enforce this. All arithmetic runs on one bit-serial
// modular multiplier (one multiplier bit per cycle) driven by a small
// sequencer, with modular add/subtract steps between products. The five input
// reductions are products by one. The inverse is z^(p-2) by square-and-multiply,
// so its number of products follows the bit length and the set-bit count of
// p-2. A doubling adds two products to a chord addition. Identity operands and
// inverse points finish after the reductions; p below 3 skips the reductions.
// pair_stall is high from acceptance until the result is moved into the output
// register; the next word is taken while that result still waits on sum_stall.
module ec_affine_point_add_top (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  ecpa_pkg::cfg_idx_t   cfg_index,
	input  ecpa_pkg::felem_t     cfg_data,
	input  logic                 pair_valid,
	output logic                 pair_stall,
	input  ecpa_pkg::pair_word_t pair,
	output logic                 sum_valid,
	input  logic                 sum_stall,
	output ecpa_pkg::sum_word_t  sum
);
	import ecpa_pkg::*;

	localparam int CNT_W = $clog2(FIELD_BITS + 1);

	// Configuration
	felem_t modulus_q, curve_a_q;

	// Sequencer
	state_t state_q, state_d, ret_q, ret_d;

	// Shared multiplier
	logic             mul_go;
	felem_t           mul_a_d, mul_b_d;
	felem_t           ma_q, mb_q, macc_q;
	logic [CNT_W-1:0] mcnt_q;
	felem_t           mstep_dbl, mstep_sum;

	// Operands and intermediates
	felem_t x1_q, y1_q, x2_q, y2_q, a_q;
	logic   inf1_q, inf2_q;
	felem_t num_q, den_q, r_q, e_q, slope_q, t_q;
	felem_t res_x_q, res_y_q;
	logic   res_inf_q;

	// Output register
	logic      sum_valid_q;
	sum_word_t sum_q;
	logic      out_load;

	// Case decisions
	logic same_x, same_y, y_sum_zero;

	assign same_x     = (x1_q == x2_q);
	assign same_y     = (y1_q == y2_q);
	assign y_sum_zero = (fadd(y1_q, y2_q, modulus_q) == '0);

	assign out_load   = (state_q == ST_DONE) && (!sum_valid_q || !sum_stall);
	assign pair_stall = (state_q != ST_IDLE);
	assign sum_valid  = sum_valid_q;
	assign sum        = sum_q;

	// One multiplier bit per cycle: double, then add the multiplicand if the bit is set
	assign mstep_dbl = fadd(macc_q, macc_q, modulus_q);
	assign mstep_sum = mb_q[FIELD_BITS-1] ? fadd(mstep_dbl, ma_q, modulus_q) : mstep_dbl;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= MODULUS_RESET;
			curve_a_q <= CURVE_A_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_MODULUS: modulus_q <= cfg_data;
				REG_CURVE_A: curve_a_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Next state and multiplier launches
	always_comb begin
		state_d = state_q;
		ret_d   = ret_q;
		mul_go  = 1'b0;
		mul_a_d = FE_ONE;
		mul_b_d = '0;
		case (state_q)
			ST_IDLE: begin
				if (pair_valid) state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (modulus_q < FE_THREE) begin
					state_d = ST_DONE;
				end else begin
					mul_go  = 1'b1;
					mul_b_d = x1_q;
					ret_d   = ST_RED_Y1;
				end
			end
			ST_RED_Y1: begin
				mul_go  = 1'b1;
				mul_b_d = y1_q;
				ret_d   = ST_RED_X2;
			end
			ST_RED_X2: begin
				mul_go  = 1'b1;
				mul_b_d = x2_q;
				ret_d   = ST_RED_Y2;
			end
			ST_RED_Y2: begin
				mul_go  = 1'b1;
				mul_b_d = y2_q;
				ret_d   = ST_RED_A;
			end
			ST_RED_A: begin
				mul_go  = 1'b1;
				mul_b_d = curve_a_q;
				ret_d   = ST_CASE;
			end
			ST_CASE: begin
				if (inf1_q || inf2_q || (same_x && y_sum_zero)) begin
					state_d = ST_DONE;
				end else if (same_x && same_y) begin
					mul_go  = 1'b1;
					mul_a_d = x1_q;
					mul_b_d = x1_q;
					ret_d   = ST_DBL_3;
				end else begin
					state_d = ST_INV;
				end
			end
			ST_DBL_3: begin
				mul_go  = 1'b1;
				mul_a_d = macc_q;
				mul_b_d = FE_THREE;
				ret_d   = ST_DBL_A;
			end
			ST_DBL_A: begin
				state_d = ST_INV;
			end
			ST_INV: begin
				mul_go = 1'b1;
				if (e_q == '0) begin
					mul_a_d = num_q;
					mul_b_d = r_q;
					ret_d   = ST_SLOPE;
				end else if (e_q[0]) begin
					mul_a_d = r_q;
					mul_b_d = den_q;
					ret_d   = ST_INV_R;
				end else begin
					mul_a_d = den_q;
					mul_b_d = den_q;
					ret_d   = ST_INV_B;
				end
			end
			ST_INV_R: begin
				mul_go  = 1'b1;
				mul_a_d = den_q;
				mul_b_d = den_q;
				ret_d   = ST_INV_B;
			end
			ST_INV_B: begin
				state_d = ST_INV;
			end
			ST_SLOPE: begin
				mul_go  = 1'b1;
				mul_a_d = macc_q;
				mul_b_d = macc_q;
				ret_d   = ST_X3A;
			end
			ST_X3A: begin
				state_d = ST_X3B;
			end
			ST_X3B: begin
				state_d = ST_Y3A;
			end
			ST_Y3A: begin
				mul_go  = 1'b1;
				mul_a_d = slope_q;
				mul_b_d = fsub(x1_q, res_x_q, modulus_q);
				ret_d   = ST_Y3B;
			end
			ST_Y3B: begin
				state_d = ST_DONE;
			end
			ST_MUL: begin
				if (mcnt_q == CNT_W'(1)) state_d = ret_q;
			end
			ST_DONE: begin
				if (!sum_valid_q || !sum_stall) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		if (mul_go) state_d = ST_MUL;
	end

	// Sequencer and multiplier control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ret_q       <= ST_IDLE;
			mcnt_q      <= '0;
			sum_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
			if (mul_go) begin
				mcnt_q <= CNT_W'(FIELD_BITS);
			end else if (state_q == ST_MUL) begin
				mcnt_q <= mcnt_q - CNT_W'(1);
			end
			if (out_load) begin
				sum_valid_q <= 1'b1;
			end else if (!sum_stall) begin
				sum_valid_q <= 1'b0;
			end
		end
	end

	// Multiplier datapath
	always_ff @(posedge clk) begin
		if (mul_go) begin
			ma_q   <= mul_a_d;
			mb_q   <= mul_b_d;
			macc_q <= '0;
		end else if (state_q == ST_MUL) begin
			macc_q <= mstep_sum;
			mb_q   <= mb_q << 1;
		end
	end

	// Operand and intermediate registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (pair_valid) begin
					x1_q   <= pair.first_x;
					y1_q   <= pair.first_y;
					inf1_q <= pair.first_inf;
					x2_q   <= pair.second_x;
					y2_q   <= pair.second_y;
					inf2_q <= pair.second_inf;
				end
			end
			ST_CHECK:  res_inf_q <= 1'b1;
			ST_RED_Y1: x1_q <= macc_q;
			ST_RED_X2: y1_q <= macc_q;
			ST_RED_Y2: x2_q <= macc_q;
			ST_RED_A:  y2_q <= macc_q;
			ST_CASE: begin
				a_q <= macc_q;
				if (inf1_q) begin
					res_x_q   <= x2_q;
					res_y_q   <= y2_q;
					res_inf_q <= inf2_q;
				end else if (inf2_q) begin
					res_x_q   <= x1_q;
					res_y_q   <= y1_q;
					res_inf_q <= 1'b0;
				end else begin
					res_inf_q <= 1'b1;
				end
				// chord operands; doubling replaces the numerator later
				num_q <= fsub(y2_q, y1_q, modulus_q);
				den_q <= (same_x && same_y) ? fadd(y1_q, y1_q, modulus_q)
				                            : fsub(x2_q, x1_q, modulus_q);
				r_q   <= FE_ONE;
				e_q   <= modulus_q - FE_TWO;
			end
			ST_DBL_A: num_q <= fadd(macc_q, a_q, modulus_q);
			ST_INV_R: r_q <= macc_q;
			ST_INV_B: begin
				den_q <= macc_q;
				e_q   <= e_q >> 1;
			end
			ST_SLOPE: slope_q <= macc_q;
			ST_X3A:   t_q <= fsub(macc_q, x1_q, modulus_q);
			ST_X3B:   res_x_q <= fsub(t_q, x2_q, modulus_q);
			ST_Y3B: begin
				res_y_q   <= fsub(macc_q, y1_q, modulus_q);
				res_inf_q <= 1'b0;
			end
			default: ;
		endcase
	end

	// Output word; the identity shows zero coordinates
	always_ff @(posedge clk) begin
		if (out_load) begin
			sum_q.sum_x   <= res_inf_q ? '0 : res_x_q;
			sum_q.sum_y   <= res_inf_q ? '0 : res_y_q;
			sum_q.sum_inf <= res_inf_q;
		end
	end

endmodule

### hw/rtl/ecpa_checker.sv
// Port-level checker for the affine point adder, bound to the top level.
// Depends on ecpa_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ecpa_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 pair_valid,
	input logic                 pair_stall,
	input ecpa_pkg::pair_word_t pair,
	input logic                 sum_valid,
	input logic                 sum_stall,
	input ecpa_pkg::sum_word_t  sum
);
	import ecpa_pkg::*;

	// A stalled result word holds
	`ASSERT_NEXT(a_sum_hold, clk, arst_n, sum_valid && sum_stall, sum_valid && $stable(sum))

	// The identity always carries zero coordinates
	`ASSERT_IMPL(a_inf_zero, clk, arst_n, sum_valid && sum.sum_inf, (sum.sum_x == '0) && (sum.sum_y == '0))

	// One word at a time: the block is busy right after taking a word
	`ASSERT_NEXT(a_busy_after_accept, clk, arst_n, pair_valid && !pair_stall, pair_stall)

	// A result never appears in the cycle right after a word is taken
	`ASSERT_NEXT(a_no_instant_result, clk, arst_n, pair_valid && !pair_stall && !sum_valid, !sum_valid)

endmodule

bind ec_affine_point_add_top ecpa_checker u_ecpa_checker (.*);
